FILE: design/smrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrq_pkg: shared definitions for the slot message ring queue
// Action, result kind and status codes, default sizes and the memory
// control bundle passed between the controller and the slot store.
// ----------------------------------------------------------------------------
package smrq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int MAX_BYTES_DEF = 60;
    localparam int CFG_W         = 5;
    localparam int COUNT_RESET   = 16;

    // input actions (tuser)
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RECV = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // result kinds (tuser)
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // send status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic size_rd;
        logic size_wr;
        logic byte_rd;
        logic byte_wr;
    } smrq_mem_ctl_t;

endpackage

FILE: design/slot_message_ring_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_message_ring_queue_core: ring queue of fixed message slots
// Stream-in send/receive/peek transactions, stream-out status and byte runs.
// ----------------------------------------------------------------------------
// Operation: after reset the block clears the slot size memory, one slot
// per cycle, and holds s_tready low until the clearing pass ends. A send
// byte that continues a message is taken in S_IDLE. The first byte of a
// message passes through S_CHECK, since the writer slot's size must be
// read from the size memory (a registered read) before the full/not-full
// verdict is known. A receive or peek passes through S_SIZE to read the
// head slot size, then streams one byte per cycle out of the byte memory
// while m_tready stays high; an empty queue answers with a single empty
// result from S_SIZE. The next transaction is taken once the block is
// back in idle and the output register is free or being drained.
// ----------------------------------------------------------------------------
module slot_message_ring_queue_core #(
    parameter int SLOTS     = smrq_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = smrq_pkg::MAX_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration: slot_count
    input  logic                       cfg_wr_en,
    input  logic [smrq_pkg::CFG_W-1:0] cfg_wr_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,  // [7:0] data_byte
    input  logic [1:0]                 s_tuser,  // [1:0] action
    input  logic                       s_tlast,  // last_byte
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,  // [1:0] send_status, [7:2] message_size,
                                                 // [15:8] out_byte
    output logic [1:0]                 m_tuser,  // [1:0] result_kind
    output logic                       m_tlast   // last_of_run
);
    import smrq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = $clog2(MAX_BYTES + 1);
    localparam int OW = $clog2(MAX_BYTES + 2);
    localparam int AW = $clog2(SLOTS * MAX_BYTES);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] COUNT_INIT =
        CW'((COUNT_RESET > SLOTS) ? SLOTS : COUNT_RESET);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,   // first send byte, waiting on writer slot size
        S_SIZE,    // receive/peek, waiting on head slot size
        S_RUN      // streaming message bytes
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] writer_reg, writer_next;
    logic [IW-1:0] reader_reg, reader_next;
    logic [AW-1:0] wbase_reg, wbase_next;    // writer * MAX_BYTES
    logic [AW-1:0] rbase_reg, rbase_next;    // reader * MAX_BYTES
    logic [CW-1:0] count_reg, count_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic [1:0]    verdict_reg, verdict_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    logic          hold_last_reg, hold_last_next;
    logic          peek_reg, peek_next;
    logic [OW-1:0] run_idx_reg, run_idx_next;
    logic [SW-1:0] run_size_reg, run_size_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_kind_reg, m_kind_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [5:0]    m_size_reg, m_size_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_last_reg, m_last_next;

    // memory interface
    smrq_mem_ctl_t ctl;
    logic [IW-1:0] size_rd_addr, size_wr_addr;
    logic [SW-1:0] size_wr_data, size_rd_data;
    logic [AW-1:0] byte_wr_addr, byte_rd_addr;
    logic [7:0]    byte_wr_data, byte_rd_data;
    logic          clr_busy;

    logic          out_free;
    logic          accept;
    logic          send_done;
    logic [1:0]    send_v;
    logic [OW-1:0] send_off;
    logic [IW-1:0] w_adv, r_adv;
    logic [31:0]   size_ext;
    logic [31:0]   cfg_v;

    smrq_slot_store #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .size_rd_addr (size_rd_addr),
        .size_wr_addr (size_wr_addr),
        .size_wr_data (size_wr_data),
        .size_rd_data (size_rd_data),
        .byte_wr_addr (byte_wr_addr),
        .byte_wr_data (byte_wr_data),
        .byte_rd_addr (byte_rd_addr),
        .byte_rd_data (byte_rd_data),
        .clr_busy     (clr_busy)
    );

    // next slot index, wrapping at the active slot count
    function automatic logic [IW-1:0] adv_idx(input logic [IW-1:0] idx,
                                               input logic [CW-1:0] cnt);
        logic [31:0] n;
        n = 32'(idx) + 32'd1;
        if (n >= 32'(cnt) || n >= 32'(SLOTS)) begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && !clr_busy && out_free;
    assign accept   = s_tvalid && s_tready;

    assign w_adv = adv_idx(writer_reg, count_reg);
    assign r_adv = adv_idx(reader_reg, count_reg);

    // memory addressing; one read and one write address per memory
    assign size_rd_addr = (s_tuser == ACT_SEND) ? writer_reg : reader_reg;
    assign size_wr_addr = (state_reg == S_RUN) ? reader_reg : writer_reg;
    assign size_wr_data = (state_reg == S_RUN) ? '0 : SW'(send_off);
    assign byte_wr_addr = wbase_reg + AW'(offset_reg);   // offset is zero in S_CHECK
    assign byte_wr_data = (state_reg == S_CHECK) ? hold_byte_reg : s_tdata;
    assign byte_rd_addr = rbase_reg + AW'(run_idx_next);

    always_comb begin
        state_next     = state_reg;
        writer_next    = writer_reg;
        reader_next    = reader_reg;
        wbase_next     = wbase_reg;
        rbase_next     = rbase_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        verdict_next   = verdict_reg;
        hold_byte_next = hold_byte_reg;
        hold_last_next = hold_last_reg;
        peek_next      = peek_reg;
        run_idx_next   = run_idx_reg;
        run_size_next  = run_size_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_status_next = m_status_reg;
        m_size_next   = m_size_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;

        ctl       = '0;
        send_done = 1'b0;
        send_v    = verdict_reg;
        send_off  = offset_reg;
        size_ext  = '0;
        cfg_v     = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        ACT_SEND: begin
                            if (offset_reg == '0) begin
                                // need the writer slot size first
                                hold_byte_next = s_tdata;
                                hold_last_next = s_tlast;
                                ctl.size_rd    = 1'b1;
                                state_next     = S_CHECK;
                            end else begin
                                if (offset_reg >= OW'(MAX_BYTES)) begin
                                    if (verdict_reg == ST_OK) begin
                                        send_v = ST_LONG;
                                    end
                                end else if (verdict_reg == ST_OK) begin
                                    ctl.byte_wr = 1'b1;
                                end
                                // saturates at MAX_BYTES + 1
                                if (offset_reg <= OW'(MAX_BYTES)) begin
                                    send_off = offset_reg + 1'b1;
                                end
                                send_done    = s_tlast;
                                offset_next  = send_off;
                                verdict_next = send_v;
                            end
                        end
                        ACT_RECV, ACT_PEEK: begin
                            ctl.size_rd = 1'b1;
                            peek_next   = (s_tuser == ACT_PEEK);
                            state_next  = S_SIZE;
                        end
                        default: begin
                            // unknown action, dropped
                        end
                    endcase
                end
            end

            S_CHECK: begin
                send_v   = (size_rd_data != '0) ? ST_FULL : ST_OK;
                ctl.byte_wr = (send_v == ST_OK);
                send_off = OW'(1);
                send_done    = hold_last_reg;
                offset_next  = send_off;
                verdict_next = send_v;
                state_next   = S_IDLE;
            end

            S_SIZE: begin
                if (size_rd_data == '0) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_EMPTY;
                    m_status_next = ST_OK;
                    m_size_next   = '0;
                    m_byte_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    run_size_next = size_rd_data;
                    run_idx_next  = '0;
                    ctl.byte_rd   = 1'b1;
                    state_next    = S_RUN;
                end
            end

            S_RUN: begin
                if (out_free) begin
                    size_ext      = 32'(run_size_reg);
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_BYTE;
                    m_status_next = ST_OK;
                    m_size_next   = size_ext[5:0];
                    m_byte_next   = byte_rd_data;
                    m_last_next   = (32'(run_idx_reg) + 32'd1 == 32'(run_size_reg));
                    if (m_last_next) begin
                        state_next = S_IDLE;
                        if (!peek_reg) begin
                            // receive frees the head slot
                            ctl.size_wr = 1'b1;
                            reader_next = r_adv;
                            rbase_next  = AW'(32'(r_adv) * 32'(MAX_BYTES));
                        end
                    end else begin
                        run_idx_next = run_idx_reg + 1'b1;
                        ctl.byte_rd  = 1'b1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // last byte of a send: status result, commit on success
        if (send_done) begin
            size_ext      = 32'(send_off);
            m_valid_next  = 1'b1;
            m_kind_next   = KIND_STATUS;
            m_status_next = send_v;
            m_size_next   = (send_v == ST_OK) ? size_ext[5:0] : 6'd0;
            m_byte_next   = '0;
            m_last_next   = 1'b1;
            if (send_v == ST_OK) begin
                ctl.size_wr = 1'b1;
                writer_next = w_adv;
                wbase_next  = AW'(32'(w_adv) * 32'(MAX_BYTES));
            end
            offset_next  = '0;
            verdict_next = ST_OK;
        end

        // slot_count write; ignored while a message is half sent
        if (cfg_wr_en && offset_reg == '0) begin
            cfg_v = 32'(cfg_wr_data);
            if (cfg_v == 32'd0) begin
                cfg_v = 32'd1;
            end
            if (cfg_v > 32'(SLOTS)) begin
                cfg_v = 32'(SLOTS);
            end
            count_next  = CW'(cfg_v);
            writer_next = '0;
            reader_next = '0;
            wbase_next  = '0;
            rbase_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            writer_reg  <= '0;
            reader_reg  <= '0;
            wbase_reg   <= '0;
            rbase_reg   <= '0;
            count_reg   <= COUNT_INIT;
            offset_reg  <= '0;
            verdict_reg <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            writer_reg  <= writer_next;
            reader_reg  <= reader_next;
            wbase_reg   <= wbase_next;
            rbase_reg   <= rbase_next;
            count_reg   <= count_next;
            offset_reg  <= offset_next;
            verdict_reg <= verdict_next;
            m_valid_reg <= m_valid_next;
        end
        hold_byte_reg <= hold_byte_next;
        hold_last_reg <= hold_last_next;
        peek_reg      <= peek_next;
        run_idx_reg   <= run_idx_next;
        run_size_reg  <= run_size_next;
        m_kind_reg    <= m_kind_next;
        m_status_reg  <= m_status_next;
        m_size_reg    <= m_size_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_byte_reg, m_size_reg, m_status_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // a read-out transaction always goes through the size lookup
    a_rd_to_size: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == ACT_RECV || s_tuser == ACT_PEEK) |=> state_reg == S_SIZE)
        else $error("receive/peek did not start a size lookup");

    // byte index stays inside the run
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RUN |-> 32'(run_idx_reg) < 32'(run_size_reg))
        else $error("run index past message size");

    // send offset saturates at MAX_BYTES + 1
    a_off_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(offset_reg) <= 32'(MAX_BYTES) + 32'd1)
        else $error("send offset beyond saturation");

    // a committed message never has zero size
    a_commit_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.size_wr && state_reg != S_RUN |-> size_wr_data != '0)
        else $error("zero-size commit");

    // nothing leaves the block while the size memory is being cleared
    a_clr_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !m_valid_reg && state_reg == S_IDLE)
        else $error("activity during clearing pass");

endmodule

FILE: design/smrq_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smrq_slot_store: slot size and message byte memories
// Two single-port-per-direction memories with registered reads, plus the
// clearing pass that zeroes every slot size after reset.
// ----------------------------------------------------------------------------
module smrq_slot_store #(
    parameter int SLOTS     = smrq_pkg::SLOTS_DEF,
    parameter int MAX_BYTES = smrq_pkg::MAX_BYTES_DEF,
    localparam int IW = $clog2(SLOTS),
    localparam int SW = $clog2(MAX_BYTES + 1),
    localparam int AW = $clog2(SLOTS * MAX_BYTES)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  smrq_pkg::smrq_mem_ctl_t ctl,
    input  logic [IW-1:0]          size_rd_addr,
    input  logic [IW-1:0]          size_wr_addr,
    input  logic [SW-1:0]          size_wr_data,
    output logic [SW-1:0]          size_rd_data,
    input  logic [AW-1:0]          byte_wr_addr,
    input  logic [7:0]             byte_wr_data,
    input  logic [AW-1:0]          byte_rd_addr,
    output logic [7:0]             byte_rd_data,
    output logic                   clr_busy
);
    import smrq_pkg::*;

    localparam int BYTE_DEPTH = SLOTS * MAX_BYTES;

    logic [SW-1:0] size_mem [SLOTS];
    logic [7:0]    byte_mem [BYTE_DEPTH];

    logic [IW-1:0] clr_reg, clr_next;
    logic          busy_reg, busy_next;
    logic [SW-1:0] size_q_reg;
    logic [7:0]    byte_q_reg;

    logic          sz_we;
    logic [IW-1:0] sz_waddr;
    logic [SW-1:0] sz_wdata;

    // clearing pass, one slot per cycle
    always_comb begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            if (clr_reg == IW'(SLOTS - 1)) begin
                busy_next = 1'b0;
            end else begin
                clr_next = clr_reg + 1'b1;
            end
        end
    end

    assign sz_we    = busy_reg | ctl.size_wr;
    assign sz_waddr = busy_reg ? clr_reg : size_wr_addr;
    assign sz_wdata = busy_reg ? '0 : size_wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            clr_reg  <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sz_we) begin
            size_mem[sz_waddr] <= sz_wdata;
        end
        if (ctl.size_rd) begin
            size_q_reg <= size_mem[size_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.byte_wr) begin
            byte_mem[byte_wr_addr] <= byte_wr_data;
        end
        if (ctl.byte_rd) begin
            byte_q_reg <= byte_mem[byte_rd_addr];
        end
    end

    assign size_rd_data = size_q_reg;
    assign byte_rd_data = byte_q_reg;
    assign clr_busy     = busy_reg;

endmodule

FILE: tb/slot_message_ring_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_message_ring_queue_core_tb: self-checking bench for the slot ring queue
// Streams send, receive and peek transactions with random gaps on both sides.
// It also changes the slot count between phases. A scoreboard class tracks the
// ring contents and checks every status, byte and empty result in order.
// ----------------------------------------------------------------------------
module slot_message_ring_queue_core_tb;

    import smrq_pkg::*;

    localparam int         CLK_PERIOD   = 4;
    localparam int         RESET_CYCLES = 8;
    localparam int         NUM_SLOTS    = SLOTS_DEF;
    localparam int         MSG_MAX      = MAX_BYTES_DEF;
    localparam int         MAX_GAP      = 12;
    localparam int         IDLE_SETTLE  = 8;   // covers a first-byte verdict still in flight
    localparam int         TAIL_CYCLES  = 32;
    localparam int         PHASE_ITEMS  = 32;
    localparam int         RANDOM_ITEMS = 166;
    localparam logic [1:0] ACT_UNUSED   = 2'd3; // ignored by the block

    // one expected result, fields as they appear on the master side
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [5:0] size;
        logic [7:0] data;
        logic       last;
    } queue_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the ring and queues the results each transaction owes
    // ------------------------------------------------------------------------
    class ring_queue_scoreboard;
        logic [7:0]    slot_data [NUM_SLOTS*MSG_MAX];
        logic [5:0]    slot_len  [NUM_SLOTS];
        int unsigned   wr_slot;
        int unsigned   rd_slot;
        int unsigned   fill_pos;
        logic [1:0]    verdict;
        int unsigned   slots_used;
        queue_result_t awaited_results [$];
        int unsigned   failures;

        function new();
            foreach (slot_len[i]) slot_len[i] = '0;
            wr_slot    = 0;
            rd_slot    = 0;
            fill_pos   = 0;
            verdict    = ST_OK;
            slots_used = COUNT_RESET;
            failures   = 0;
        endfunction

        function int unsigned next_slot(int unsigned idx);
            int unsigned n;
            n = idx + 1;
            return (n >= slots_used || n >= NUM_SLOTS) ? 0 : n;
        endfunction

        // a write in the middle of a message is dropped by the block
        function void note_slot_count(logic [CFG_W-1:0] value);
            int unsigned v;
            if (fill_pos != 0) return;
            v = 32'(value);
            if (v == 0) v = 1;
            if (v > NUM_SLOTS) v = NUM_SLOTS;
            slots_used = v;
            wr_slot    = 0;
            rd_slot    = 0;
        endfunction

        function void predict_item(logic [1:0] act, logic [7:0] data, logic last);
            queue_result_t res;
            int unsigned   len;
            res = '0;
            if (act == ACT_SEND) begin
                // the full/not-full verdict is taken on the first byte only
                if (fill_pos == 0)
                    verdict = (slot_len[wr_slot] != 0) ? ST_FULL : ST_OK;
                if (fill_pos >= MSG_MAX) begin
                    if (verdict == ST_OK) verdict = ST_LONG;
                end else if (verdict == ST_OK) begin
                    slot_data[wr_slot*MSG_MAX + fill_pos] = data;
                end
                if (fill_pos <= MSG_MAX) fill_pos++;
                if (!last) return;
                res.kind   = KIND_STATUS;
                res.status = verdict;
                res.last   = 1'b1;
                if (verdict == ST_OK) begin
                    res.size          = fill_pos[5:0];
                    slot_len[wr_slot] = fill_pos[5:0];
                    wr_slot           = next_slot(wr_slot);
                end
                fill_pos = 0;
                verdict  = ST_OK;
                awaited_results.push_back(res);
            end else if (act == ACT_RECV || act == ACT_PEEK) begin
                len = 32'(slot_len[rd_slot]);
                if (len == 0) begin
                    res.kind = KIND_EMPTY;
                    res.last = 1'b1;
                    awaited_results.push_back(res);
                    return;
                end
                for (int i = 0; i < len; i++) begin
                    res.kind = KIND_BYTE;
                    res.size = len[5:0];
                    res.data = slot_data[rd_slot*MSG_MAX + i];
                    res.last = (i + 1 == len);
                    awaited_results.push_back(res);
                end
                if (act == ACT_RECV) begin
                    slot_len[rd_slot] = '0;
                    rd_slot           = next_slot(rd_slot);
                end
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
            queue_result_t want;
            if (awaited_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, tuser, tdata);
                return;
            end
            want = awaited_results.pop_front();
            compare("result_kind",  32'(want.kind),   32'(tuser));
            compare("send_status",  32'(want.status), 32'(tdata[1:0]));
            compare("message_size", 32'(want.size),   32'(tdata[7:2]));
            compare("out_byte",     32'(want.data),   32'(tdata[15:8]));
            compare("last_of_run",  32'(want.last),   32'(tlast));
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] data_byte
    logic [1:0]       s_tuser;   // [1:0] action
    logic             s_tlast;   // last_byte
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;   // [1:0] send_status, [7:2] message_size, [15:8] out_byte
    logic [1:0]       m_tuser;   // [1:0] result_kind
    logic             m_tlast;   // last_of_run

    ring_queue_scoreboard sb;
    logic                 rst_done = 1'b0;
    logic                 calm     = 1'b0;   // both sides run back to back while set
    int unsigned          items_sent = 0;

    slot_message_ring_queue_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("slot_message_ring_queue_core_tb NOT OK");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // mostly short messages, a few at the size limit and a few past it
    function automatic int unsigned draw_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return $urandom_range(1, 6);
        if (pick < 85) return $urandom_range(7, MSG_MAX - 1);
        if (pick < 93) return MSG_MAX;
        return $urandom_range(MSG_MAX + 1, 64);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Every task is entered right after a rising edge. tvalid is
    // dropped only when a gap is drawn or the bench drains, so back-to-back
    // transactions keep it high without a glitch.
    // ------------------------------------------------------------------------
    task automatic drive_item(input logic [1:0] act, input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_item(act, data, last);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int i = 0; i < len; i++)
            drive_item(ACT_SEND, 8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // a message with a read or an ignored transaction wedged between its bytes
    task automatic send_broken_message();
        int unsigned len;
        int unsigned cut;
        logic [1:0]  wedge;
        len = $urandom_range(2, 6);
        cut = $urandom_range(1, len - 1);
        case ($urandom_range(0, 2))
            0: begin wedge = ACT_RECV; end
            1: begin wedge = ACT_PEEK; end
            default: begin wedge = ACT_UNUSED; end
        endcase
        for (int i = 0; i < len; i++) begin
            if (i == cut)
                drive_item(wedge, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            drive_item(ACT_SEND, 8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // drop tvalid, then wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // the register is only touched with the block idle and no message open
    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (IDLE_SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.note_slot_count(value);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                drive_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 60)
                send_message(draw_length());
            else if (pick < 78)
                drive_item(ACT_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 93)
                drive_item(ACT_PEEK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 98)
                send_broken_message();
            else
                wait_drained();  // let the result side catch up completely
            if ($urandom_range(0, 19) == 0) calm = ~calm;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: a random stall before each result, then check it
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        wait (rst_done);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_base;
        int unsigned phase;
        logic [CFG_W-1:0] count_value;

        sb          = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_SEND;
        s_tlast     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn  <= 1'b1;
        rst_done <= 1'b1;

        // reset slot count: empty reads, an ignored action, short messages
        drive_item(ACT_RECV, 8'h00, 1'b0);
        drive_item(ACT_PEEK, 8'hFF, 1'b1);
        drive_item(ACT_UNUSED, 8'hFF, 1'b1);
        drive_item(ACT_SEND, 8'h00, 1'b1);
        drive_item(ACT_SEND, 8'hFF, 1'b0);
        drive_item(ACT_SEND, 8'h55, 1'b1);
        drive_item(ACT_PEEK, 8'h00, 1'b0);
        drive_item(ACT_RECV, 8'h00, 1'b0);
        drive_item(ACT_RECV, 8'hAA, 1'b1);
        drive_item(ACT_RECV, 8'h00, 1'b0);
        // longest message that fits, then one byte too many
        send_message(MSG_MAX);
        send_message(MSG_MAX + 1);
        drive_item(ACT_RECV, 8'h00, 1'b0);
        drive_item(ACT_PEEK, 8'h00, 1'b0);

        // single slot: full rejection, including an over-long message on it
        write_slot_count(5'd1);
        drive_item(ACT_SEND, 8'hA5, 1'b1);
        drive_item(ACT_SEND, 8'h5A, 1'b1);
        drive_item(ACT_SEND, 8'h11, 1'b0);
        drive_item(ACT_SEND, 8'h22, 1'b1);
        send_message(MSG_MAX + 2);
        drive_item(ACT_PEEK, 8'h00, 1'b0);
        drive_item(ACT_RECV, 8'h00, 1'b0);
        drive_item(ACT_SEND, 8'h33, 1'b1);
        drive_item(ACT_RECV, 8'h00, 1'b0);
        drive_item(ACT_RECV, 8'h00, 1'b0);

        // random phases: zero and out-of-range counts clamp, then assorted sizes
        random_base = items_sent;
        phase = 0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            case (phase)
                0: begin count_value = 5'd0; end
                1: begin count_value = 5'd31; end
                2: begin count_value = 5'd2; end
                3: begin count_value = 5'd16; end
                4: begin count_value = 5'd3; end
                default: begin count_value = 5'($urandom_range(0, 31)); end
            endcase
            write_slot_count(count_value);
            calm = (phase == 2);
            run_random_phase(PHASE_ITEMS);
            phase++;
        end

        // everything sent: wait for the tail, then give stray results a chance
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("slot_message_ring_queue_core_tb OK");
        else
            $display("slot_message_ring_queue_core_tb NOT OK");
        $finish;
    end

endmodule
